### hdl/uyvy_pkg.sv
// Shared types, constants and the clamp function of the UYVY to BGR888 converter.
package uyvy_pkg;

  localparam int PIX_W        = 8;
  localparam int FRAC_BITS    = 12;
  localparam int SUM_W        = 23;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int OFFSET_W     = 26;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd320;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_PAIRS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic signed [8:0]  CHROMA_BIAS = 9'sd128;
  localparam logic signed [13:0] COEF_BU     = 14'sd7250;
  localparam logic signed [13:0] COEF_GU     = 14'sd1409;
  localparam logic signed [13:0] COEF_GV     = 14'sd2925;
  localparam logic signed [13:0] COEF_RV     = 14'sd5747;
  localparam logic [PIX_W-1:0]   PIX_MAX     = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] chroma_u;
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_v;
    logic [PIX_W-1:0] luma_second;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0]    blue_first;
    logic [PIX_W-1:0]    green_first;
    logic [PIX_W-1:0]    red_first;
    logic [PIX_W-1:0]    blue_second;
    logic [PIX_W-1:0]    green_second;
    logic [PIX_W-1:0]    red_second;
    logic [OFFSET_W-1:0] byte_offset;
    logic                frame_last;
  } result_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] blue;
    logic signed [SUM_W-1:0] green;
    logic signed [SUM_W-1:0] red;
  } chroma_delta_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } bgr_t;

  typedef struct packed {
    logic                   write;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

  // Truncates a signed Q.12 sum toward zero and clamps it to a byte.
  function automatic logic [PIX_W-1:0] clamp_q12(input logic signed [SUM_W-1:0] sum);
    logic [SUM_W-FRAC_BITS-2:0] whole;
    whole = sum[SUM_W-2:FRAC_BITS];
    if (sum[SUM_W-1] || (sum == '0)) begin
      return '0;
    end else if (whole > (SUM_W-FRAC_BITS-1)'(PIX_MAX)) begin
      return PIX_MAX;
    end else begin
      return whole[PIX_W-1:0];
    end
  endfunction

endpackage

### hdl/uyvy_lane.sv
// One pixel lane: adds the luma to the shared chroma terms and clamps B, G and R.
module uyvy_lane (
  input  logic                          clk,
  input  logic                          advance,
  input  logic [uyvy_pkg::PIX_W-1:0]    luma,
  input  uyvy_pkg::chroma_delta_t       delta,
  output uyvy_pkg::bgr_t                color
);

  logic signed [uyvy_pkg::SUM_W-1:0] luma_q;
  logic signed [uyvy_pkg::SUM_W-1:0] sum_blue;
  logic signed [uyvy_pkg::SUM_W-1:0] sum_green;
  logic signed [uyvy_pkg::SUM_W-1:0] sum_red;

  assign luma_q    = $signed(uyvy_pkg::SUM_W'({luma, {uyvy_pkg::FRAC_BITS{1'b0}}}));
  assign sum_blue  = luma_q + delta.blue;
  assign sum_green = luma_q + delta.green;
  assign sum_red   = luma_q + delta.red;

  always_ff @(posedge clk) begin
    if (advance) begin
      color.blue  <= uyvy_pkg::clamp_q12(sum_blue);
      color.green <= uyvy_pkg::clamp_q12(sum_green);
      color.red   <= uyvy_pkg::clamp_q12(sum_red);
    end
  end

endmodule

### hdl/uyvy_addr.sv
// Frame geometry registers, raster counters and the two-stage byte offset pipeline.
module uyvy_addr #(
  parameter int MAX_PAIRS = 2048,
  parameter int MAX_ROWS  = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  uyvy_pkg::cfg_write_t            cfg,
  input  logic                            accept,
  input  logic                            advance_first,
  input  logic                            advance_second,
  output logic [uyvy_pkg::OFFSET_W-1:0]   byte_offset,
  output logic                            frame_last
);

  localparam int EW_W = $clog2(MAX_PAIRS + 1);
  localparam int EH_W = $clog2(MAX_ROWS + 1);
  localparam int CW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int PW   = EW_W + EH_W;
  localparam int SW   = (PW + 1 > uyvy_pkg::OFFSET_W) ? PW + 1 : uyvy_pkg::OFFSET_W;

  logic [uyvy_pkg::WIDTH_REG_W-1:0]  width_pairs;
  logic [uyvy_pkg::HEIGHT_REG_W-1:0] frame_height;
  logic [CW-1:0]   pair_column;
  logic [RW-1:0]   row_index;
  logic [EW_W-1:0] eff_width;
  logic [EH_W-1:0] eff_height;
  logic [EH_W-1:0] rows_below;
  logic            column_last;
  logic            row_last;
  logic            cfg_hit;

  logic [PW-1:0]   row_base;
  logic [CW-1:0]   column_s1;
  logic            last_s1;
  logic [SW-1:0]   pair_index;

  always_comb begin
    if (width_pairs == '0) begin
      eff_width = EW_W'(1);
    end else if (32'(width_pairs) > MAX_PAIRS) begin
      eff_width = EW_W'(MAX_PAIRS);
    end else begin
      eff_width = EW_W'(width_pairs);
    end
    if (frame_height == '0) begin
      eff_height = EH_W'(1);
    end else if (32'(frame_height) > MAX_ROWS) begin
      eff_height = EH_W'(MAX_ROWS);
    end else begin
      eff_height = EH_W'(frame_height);
    end
  end

  assign column_last = (EW_W'(pair_column) == eff_width - EW_W'(1));
  assign row_last    = (EH_W'(row_index) == eff_height - EH_W'(1));
  assign rows_below  = eff_height - EH_W'(1) - EH_W'(row_index);

  always_comb begin
    unique case (cfg.index)
      uyvy_pkg::REG_WIDTH_PAIRS:  cfg_hit = cfg.write;
      uyvy_pkg::REG_FRAME_HEIGHT: cfg_hit = cfg.write;
      default:                    cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_pairs  <= uyvy_pkg::WIDTH_RESET;
      frame_height <= uyvy_pkg::HEIGHT_RESET;
      pair_column  <= '0;
      row_index    <= '0;
    end else if (cfg_hit) begin
      if (cfg.index == uyvy_pkg::REG_WIDTH_PAIRS) begin
        width_pairs <= cfg.data[uyvy_pkg::WIDTH_REG_W-1:0];
      end else begin
        frame_height <= cfg.data[uyvy_pkg::HEIGHT_REG_W-1:0];
      end
      pair_column <= '0;
      row_index   <= '0;
    end else if (accept) begin
      if (column_last) begin
        pair_column <= '0;
        row_index   <= row_last ? '0 : row_index + 1'b1;
      end else begin
        pair_column <= pair_column + 1'b1;
      end
    end
  end

  // First stage: start of the pair's row in the bottom-up frame, in pairs.
  always_ff @(posedge clk) begin
    if (advance_first) begin
      row_base  <= PW'(rows_below) * PW'(eff_width);
      column_s1 <= pair_column;
      last_s1   <= column_last && row_last;
    end
  end

  // Second stage: add the column and scale by six bytes per pair.
  assign pair_index = SW'(row_base) + SW'(column_s1);

  always_ff @(posedge clk) begin
    if (advance_second) begin
      byte_offset <= uyvy_pkg::OFFSET_W'((pair_index << 2) + (pair_index << 1));
      frame_last  <= last_s1;
    end
  end

endmodule

### hdl/uyvy_to_bgr888_converter.sv
// Top level of the UYVY to BGR888 converter: chroma stage, two pixel lanes, merge.
//
//   Channel  Direction  Handshake               Beat contents
//   pixel    in         pixel_valid/pixel_stall  one UYVY quad (U, Y0, V, Y1)
//   result   out        result_valid/result_stall two BGR pixels, offset, last flag
//   cfg      in         cfg_valid/cfg_ready      register index and write data
//
// Each beat is registered in the first stage, then in the output register: the
// first stage forms the chroma products and the row base multiply, the second
// stage runs the two pixel lanes and the offset adder. While result_stall is low
// a new beat is accepted every cycle; the rate is one beat per clock, set by the
// single multiplier stage on each path. Reset is synchronous and restores a
// 320 x 480 pair frame with both counters at zero. A stalled result holds the
// output register while the first stage can still take one more beat, so the
// input side stalls only when both stages are full and the output is stalled.
module uyvy_to_bgr888_converter #(
  parameter int MAX_PAIRS = 2048,
  parameter int MAX_ROWS  = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  uyvy_pkg::pixel_t                    pixel,
  output logic                                result_valid,
  input  logic                                result_stall,
  output uyvy_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [uyvy_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [uyvy_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                       s1_valid;
  logic                       advance_first;
  logic                       advance_second;
  logic                       accept;
  logic signed [8:0]          u_centered;
  logic signed [8:0]          v_centered;
  uyvy_pkg::chroma_delta_t    delta_next;
  uyvy_pkg::chroma_delta_t    delta;
  logic [uyvy_pkg::PIX_W-1:0] luma_first;
  logic [uyvy_pkg::PIX_W-1:0] luma_second;
  uyvy_pkg::bgr_t             color_first;
  uyvy_pkg::bgr_t             color_second;
  uyvy_pkg::cfg_write_t       cfg;

  // The output register moves when it is empty or being taken; the first
  // stage moves when it is empty or can pass its beat forward.
  assign advance_second = !result_valid || !result_stall;
  assign advance_first  = !s1_valid || advance_second;
  assign pixel_stall    = !advance_first;
  assign accept         = pixel_valid && !pixel_stall;

  // Configuration is only written while the pipeline is idle: no beat in
  // either stage and no pixel beat being offered in the same cycle.
  assign cfg_ready = !s1_valid && !result_valid && !pixel_valid;
  assign cfg.write = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (advance_first) begin
        s1_valid <= accept;
      end
      if (advance_second) begin
        result_valid <= s1_valid;
      end
    end
  end

  // Chroma terms are shared by both pixels of the pair.
  assign u_centered = $signed({1'b0, pixel.chroma_u}) - uyvy_pkg::CHROMA_BIAS;
  assign v_centered = $signed({1'b0, pixel.chroma_v}) - uyvy_pkg::CHROMA_BIAS;

  always_comb begin
    delta_next.blue  = uyvy_pkg::SUM_W'(u_centered) * uyvy_pkg::SUM_W'(uyvy_pkg::COEF_BU);
    delta_next.green = -((uyvy_pkg::SUM_W'(u_centered) * uyvy_pkg::SUM_W'(uyvy_pkg::COEF_GU))
                       + (uyvy_pkg::SUM_W'(v_centered) * uyvy_pkg::SUM_W'(uyvy_pkg::COEF_GV)));
    delta_next.red   = uyvy_pkg::SUM_W'(v_centered) * uyvy_pkg::SUM_W'(uyvy_pkg::COEF_RV);
  end

  always_ff @(posedge clk) begin
    if (advance_first) begin
      delta       <= delta_next;
      luma_first  <= pixel.luma_first;
      luma_second <= pixel.luma_second;
    end
  end

  uyvy_lane u_lane_first (
    .clk     (clk),
    .advance (advance_second),
    .luma    (luma_first),
    .delta   (delta),
    .color   (color_first)
  );

  uyvy_lane u_lane_second (
    .clk     (clk),
    .advance (advance_second),
    .luma    (luma_second),
    .delta   (delta),
    .color   (color_second)
  );

  uyvy_addr #(
    .MAX_PAIRS (MAX_PAIRS),
    .MAX_ROWS  (MAX_ROWS)
  ) u_addr (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (accept),
    .advance_first  (advance_first),
    .advance_second (advance_second),
    .byte_offset    (result.byte_offset),
    .frame_last     (result.frame_last)
  );

  // Merge the two lanes into the result beat.
  assign result.blue_first   = color_first.blue;
  assign result.green_first  = color_first.green;
  assign result.red_first    = color_first.red;
  assign result.blue_second  = color_second.blue;
  assign result.green_second = color_second.green;
  assign result.red_second   = color_second.red;

  // The input never stalls while the output register is empty.
  assert property (@(posedge clk) disable iff (rst) !result_valid |-> !pixel_stall)
    else $error("input stalled with an empty output register");

  // A beat in the first stage reaches the output once the output can move.
  assert property (@(posedge clk) disable iff (rst) s1_valid && advance_second |=> result_valid)
    else $error("beat lost between first stage and output");

  // With nothing behind it, a taken result leaves the output empty.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !s1_valid |=> !result_valid)
    else $error("result repeated after it was taken");

endmodule
